[hw/rtl/sfb_pkg.sv]
// Package for the shape fit-to-box block: widths, constants, state encoding
// and the command/status structs between controller and datapath.
// No dependencies.
package sfb_pkg;

   localparam int MAX_POINTS_DEF      = 64;
   localparam int COORD_FRAC_BITS_DEF = 8;

   localparam int COORD_W  = 24;
   localparam int BOX_W    = 12;
   localparam int TRIG_W   = 16;
   localparam int CENTRE_W = 21;
   localparam int SUM_W    = 31;

   // configuration register indexes
   localparam logic [2:0] REG_BOX_LEFT   = 3'd0;
   localparam logic [2:0] REG_BOX_TOP    = 3'd1;
   localparam logic [2:0] REG_BOX_WIDTH  = 3'd2;
   localparam logic [2:0] REG_BOX_HEIGHT = 3'd3;
   localparam logic [2:0] REG_COS        = 3'd4;
   localparam logic [2:0] REG_SIN        = 3'd5;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MEAN,
      ST_MEAN_WAIT,
      ST_SCALE,
      ST_TRIG,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // store and accumulate the accepted point
      logic start_mean;  // start both mean divisions
      logic start_scale; // pick the term and start the scale division
      logic trig;        // form scaled cos and sin
      logic emit_first;  // first read of the store
      logic emit_next;   // output taken, advance the walk
      logic clear;       // empty the set
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;       // no point stored in the set
      logic div_busy;
      logic out_valid;
      logic walk_done;   // last stored point is in the output register
   } dp_stat_type;

endpackage

[hw/rtl/sfb_if.sv]
// Valid/ready channel carrying one payload of parameterised width.
// Depends on nothing.
interface sfb_if #(
   parameter int WIDTH = 8
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/sfb_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing.
module sfb_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             busy,
   output logic [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   trial;

   // shift one numerator bit in, subtract when it fits
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[DEN_W-1:0], quot_ff[NUM_W-1]};
      if (start) begin
         quot_in = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial - {1'b0, den_ff};
            quot_in = {quot_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign quot = quot_ff;
endmodule

[hw/rtl/sfb_ctrl.sv]
// Sequencer: load, means, scale, trig factors, walk over the store.
// Depends on sfb_pkg.
module sfb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   input  sfb_pkg::dp_stat_type stat,
   output sfb_pkg::dp_cmd_type  cmd
);
   import sfb_pkg::*;

   state_type state_ff, state_in;
   logic      wait_ff, wait_in;   // division started, busy not yet seen

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         wait_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      wait_in   = 1'b0;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) state_in = ST_MEAN;
            end
         end
         // sums and count now include the last point
         ST_MEAN: begin
            if (stat.empty) begin
               state_in  = ST_LOAD;
               cmd.clear = 1'b1;
            end else begin
               state_in       = ST_MEAN_WAIT;
               cmd.start_mean = 1'b1;
               wait_in        = 1'b1;
            end
         end
         ST_MEAN_WAIT: begin
            if (!wait_ff && !stat.div_busy) begin
               state_in        = ST_SCALE;
               cmd.start_scale = 1'b1;
               wait_in         = 1'b1;
            end
         end
         ST_SCALE: begin
            if (!wait_ff && !stat.div_busy) begin
               state_in = ST_TRIG;
               cmd.trig = 1'b1;
            end
         end
         ST_TRIG: begin
            state_in       = ST_EMIT;
            cmd.emit_first = 1'b1;
         end
         ST_EMIT: begin
            if (stat.out_valid && rsp_ready) begin
               if (stat.walk_done) begin
                  state_in  = ST_LOAD;
                  cmd.clear = 1'b1;
               end else begin
                  cmd.emit_next = 1'b1;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end
endmodule

[hw/rtl/sfb_dp.sv]
// Datapath: point store, sums and extents, dividers, placement pipeline.
// Depends on sfb_pkg and sfb_div.
module sfb_dp #(
   parameter int MAX_POINTS      = sfb_pkg::MAX_POINTS_DEF,
   parameter int COORD_FRAC_BITS = sfb_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sfb_pkg::dp_cmd_type                   cmd,
   output sfb_pkg::dp_stat_type                  stat,
   input  logic signed [sfb_pkg::COORD_W-1:0]    point_x,
   input  logic signed [sfb_pkg::COORD_W-1:0]    point_y,
   input  logic [sfb_pkg::BOX_W-1:0]             box_left,
   input  logic [sfb_pkg::BOX_W-1:0]             box_top,
   input  logic [sfb_pkg::BOX_W-1:0]             box_width,
   input  logic [sfb_pkg::BOX_W-1:0]             box_height,
   input  logic signed [sfb_pkg::TRIG_W-1:0]     cos_rotation,
   input  logic signed [sfb_pkg::TRIG_W-1:0]     sin_rotation,
   input  logic                                  rsp_ready,
   output logic signed [sfb_pkg::COORD_W-1:0]    out_x,
   output logic signed [sfb_pkg::COORD_W-1:0]    out_y,
   output logic signed [sfb_pkg::COORD_W-1:0]    scaled_cos,
   output logic signed [sfb_pkg::COORD_W-1:0]    scaled_sin,
   output logic [sfb_pkg::CENTRE_W-1:0]          center_x,
   output logic [sfb_pkg::CENTRE_W-1:0]          center_y,
   output logic                                  last_out
);
   import sfb_pkg::*;

   localparam int IDX_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int MNUM_W  = SUM_W + 2;            // 2*|sum| + n
   localparam int SNUM_W  = BOX_W + COORD_FRAC_BITS + 16;
   localparam int EXT_W   = COORD_W + 1;
   localparam logic [23:0] SCALE_MAX = 24'hFFFFFF;

   // ---------------- store and accumulation ----------------
   logic [2*COORD_W-1:0]      store_mem [MAX_POINTS];
   logic [2*COORD_W-1:0]      rd_data_ff;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [SUM_W-1:0]   sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic signed [COORD_W-1:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic signed [COORD_W-1:0] min_x_in, max_x_in, min_y_in, max_y_in;
   logic                      room;
   logic [IDX_W-1:0]          wr_idx, rd_idx;
   logic [CNT_W-1:0]          walk_ff, walk_in;

   assign room   = count_ff < CNT_W'(MAX_POINTS);
   assign wr_idx = count_ff[IDX_W-1:0];

   always_comb begin
      count_in = count_ff;
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      min_x_in = min_x_ff;
      max_x_in = max_x_ff;
      min_y_in = min_y_ff;
      max_y_in = max_y_ff;
      if (cmd.clear) begin
         count_in = '0;
         sum_x_in = '0;
         sum_y_in = '0;
      end else if (cmd.load && room) begin
         count_in = count_ff + 1'b1;
         sum_x_in = sum_x_ff + SUM_W'(point_x);
         sum_y_in = sum_y_ff + SUM_W'(point_y);
         if (count_ff == '0 || point_x < min_x_ff) min_x_in = point_x;
         if (count_ff == '0 || point_x > max_x_ff) max_x_in = point_x;
         if (count_ff == '0 || point_y < min_y_ff) min_y_in = point_y;
         if (count_ff == '0 || point_y > max_y_ff) max_y_in = point_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
      end else begin
         count_ff <= count_in;
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
      end
      min_x_ff <= min_x_in;
      max_x_ff <= max_x_in;
      min_y_ff <= min_y_in;
      max_y_ff <= max_y_in;
   end

   // store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load && room) store_mem[wr_idx] <= {point_x, point_y};
      rd_data_ff <= store_mem[rd_idx];
   end

   assign stat.empty = (count_ff == '0);

   // ---------------- means: floor((2s+n)/(2n)) via magnitude division ----
   // negative numerators use floor(-a/b) = -ceil(a/b) = -floor((a+b-1)/b)
   logic [MNUM_W-1:0] mnum_x, mnum_y, mq_x, mq_y;
   logic [CNT_W:0]    mden;
   logic              neg_x_ff, neg_y_ff;
   logic              mbusy_x, mbusy_y;
   logic signed [MNUM_W:0] tx, ty;

   assign mden = {count_ff, 1'b0};
   always_comb begin
      tx = (MNUM_W+1)'(sum_x_ff) * 2 + (MNUM_W+1)'(count_ff);
      ty = (MNUM_W+1)'(sum_y_ff) * 2 + (MNUM_W+1)'(count_ff);
      mnum_x = tx[MNUM_W] ? MNUM_W'(-tx + (MNUM_W+1)'(mden) - 1)
                          : MNUM_W'(tx);
      mnum_y = ty[MNUM_W] ? MNUM_W'(-ty + (MNUM_W+1)'(mden) - 1)
                          : MNUM_W'(ty);
   end

   always_ff @(posedge clock) begin
      if (cmd.start_mean) begin
         neg_x_ff <= tx[MNUM_W];
         neg_y_ff <= ty[MNUM_W];
      end
   end

   sfb_div #(.NUM_W(MNUM_W), .DEN_W(CNT_W+1)) u_div_mx (
      .clock, .reset, .start(cmd.start_mean), .numer(mnum_x), .denom(mden),
      .busy(mbusy_x), .quot(mq_x));
   sfb_div #(.NUM_W(MNUM_W), .DEN_W(CNT_W+1)) u_div_my (
      .clock, .reset, .start(cmd.start_mean), .numer(mnum_y), .denom(mden),
      .busy(mbusy_y), .quot(mq_y));

   logic signed [COORD_W:0] mean_x, mean_y;
   assign mean_x = neg_x_ff ? -(COORD_W+1)'(mq_x) : (COORD_W+1)'(mq_x);
   assign mean_y = neg_y_ff ? -(COORD_W+1)'(mq_y) : (COORD_W+1)'(mq_y);

   // ---------------- scale ----------------
   logic [EXT_W-1:0]        wd, ht;
   logic [EXT_W+BOX_W-1:0]  prod_w, prod_h;
   logic                    use_w, both_zero_ff;
   logic [SNUM_W-1:0]       snum, squot;
   logic [EXT_W-1:0]        sden;
   logic                    sbusy;

   assign wd = EXT_W'(max_x_ff) - EXT_W'(min_x_ff);
   assign ht = EXT_W'(max_y_ff) - EXT_W'(min_y_ff);

   always_ff @(posedge clock) begin
      prod_w <= box_width * ht;
      prod_h <= box_height * wd;
   end

   assign use_w = (wd != '0) && (prod_w <= prod_h);
   assign snum  = (use_w ? box_width : box_height) << (COORD_FRAC_BITS + 16);
   assign sden  = use_w ? wd : ht;

   always_ff @(posedge clock) begin
      if (cmd.start_scale) both_zero_ff <= (wd == '0) && (ht == '0);
   end

   sfb_div #(.NUM_W(SNUM_W), .DEN_W(EXT_W)) u_div_sc (
      .clock, .reset, .start(cmd.start_scale), .numer(snum), .denom(sden),
      .busy(sbusy), .quot(squot));

   assign stat.div_busy = mbusy_x | mbusy_y | sbusy;

   logic [23:0] scale;
   assign scale = (both_zero_ff || squot > SNUM_W'(SCALE_MAX)) ? SCALE_MAX : squot[23:0];

   // ---------------- scaled cos/sin and centre ----------------
   logic signed [COORD_W-1:0] sc_ff, ss_ff;
   logic signed [41:0]        pc, ps, rc, rs;

   function automatic logic signed [COORD_W-1:0] sat24(input logic signed [47:0] v);
      if (v > 48'sd8388607)       return 24'sh7FFFFF;
      else if (v < -48'sd8388608) return 24'sh800000;
      else                        return v[COORD_W-1:0];
   endfunction

   assign pc = $signed({18'd0, scale}) * cos_rotation;
   assign ps = $signed({18'd0, scale}) * sin_rotation;
   assign rc = (pc + 42'sd16384) >>> 15;
   assign rs = (ps + 42'sd16384) >>> 15;

   always_ff @(posedge clock) begin
      if (cmd.trig) begin
         sc_ff <= sat24(48'(rc));
         ss_ff <= sat24(48'(rs));
      end
   end

   logic [BOX_W+COORD_FRAC_BITS:0] cxr, cyr;
   assign cxr = ({1'b0, box_left, 1'b0} + (BOX_W+2)'(box_width)) << (COORD_FRAC_BITS - 1);
   assign cyr = ({1'b0, box_top, 1'b0} + (BOX_W+2)'(box_height)) << (COORD_FRAC_BITS - 1);
   assign center_x = (cxr > (BOX_W+COORD_FRAC_BITS+1)'(21'h1FFFFF)) ? 21'h1FFFFF
                                                                    : CENTRE_W'(cxr);
   assign center_y = (cyr > (BOX_W+COORD_FRAC_BITS+1)'(21'h1FFFFF)) ? 21'h1FFFFF
                                                                    : CENTRE_W'(cyr);

   // ---------------- walk: read, differences, products, sums ----------
   // pipeline: read -> diff -> four products -> combine/output (one in flight)
   logic                        p1_ff, p2_ff, p3_ff, p4_ff, ov_ff;
   logic signed [COORD_W+1:0]   dx_ff, dy_ff;
   logic signed [50:0]          m_cx_ff, m_sy_ff, m_cy_ff, m_sx_ff;
   logic signed [52:0]          ax, ay;
   logic signed [COORD_W-1:0]   ox_ff, oy_ff;
   logic                        last_ff;

   assign walk_in = cmd.clear ? '0 :
                    (cmd.emit_first || cmd.emit_next) ? walk_ff + 1'b1 : walk_ff;
   assign rd_idx  = walk_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) walk_ff <= '0;
      else       walk_ff <= walk_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff <= 1'b0; p2_ff <= 1'b0; p3_ff <= 1'b0; p4_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         p1_ff <= cmd.emit_first || cmd.emit_next;
         p2_ff <= p1_ff;
         p3_ff <= p2_ff;
         p4_ff <= p3_ff;
         if (p4_ff)                  ov_ff <= 1'b1;
         else if (ov_ff && rsp_ready) ov_ff <= 1'b0;
      end
   end

   // read data is valid in the cycle after the read; the address has already moved on
   always_ff @(posedge clock) begin
      if (p1_ff) begin
         dx_ff <= (COORD_W+2)'($signed(rd_data_ff[2*COORD_W-1:COORD_W])) - (COORD_W+2)'(mean_x);
         dy_ff <= (COORD_W+2)'($signed(rd_data_ff[COORD_W-1:0])) - (COORD_W+2)'(mean_y);
      end
      if (p3_ff) begin
         m_cx_ff <= sc_ff * dx_ff;
         m_sy_ff <= ss_ff * dy_ff;
         m_cy_ff <= sc_ff * dy_ff;
         m_sx_ff <= ss_ff * dx_ff;
      end
      if (p4_ff) begin
         ox_ff   <= sat24(48'(((ax + 53'sd32768) >>> 16) + $signed({1'b0, center_x})));
         oy_ff   <= sat24(48'(((ay + 53'sd32768) >>> 16) + $signed({1'b0, center_y})));
         last_ff <= (walk_ff == count_ff);
      end
   end

   assign ax = 53'(m_cx_ff) + 53'(m_sy_ff);
   assign ay = 53'(m_cy_ff) - 53'(m_sx_ff);

   assign stat.out_valid = ov_ff;
   assign stat.walk_done = last_ff;
   assign out_x      = ox_ff;
   assign out_y      = oy_ff;
   assign scaled_cos = sc_ff;
   assign scaled_sin = ss_ff;
   assign last_out   = last_ff;
endmodule

[hw/rtl/shape_fit_to_box_transform.sv]
// Top level of the shape fit-to-box block: configuration registers,
// controller and datapath. Depends on sfb_pkg, sfb_if, sfb_ctrl, sfb_dp.
//
// Usage: points arrive on req (point_x, point_y, last_point), one per cycle
// while loading. Each transfer stores the point and updates sums and extents.
// A transfer with last_point closes the set; req_ready then stays low while
// two mean divisions (one quotient bit per cycle), the scale division and a
// trig step run. The stored points are then walked, one store read per
// result; each result passes through read, difference, multiply and combine
// stages, and the next read starts only when a result is transferred. Points
// past MAX_POINTS are dropped. The final result carries last_out. If
// rsp_ready is low the result is held in its output register and the walk
// waits. Reset (synchronous) empties the set and loads the registers' reset
// values; the store itself is not cleared. Configuration is to be written
// through csr_ only while the block is idle; the block does not enforce it.
module shape_fit_to_box_transform #(
   parameter int MAX_POINTS      = sfb_pkg::MAX_POINTS_DEF,
   parameter int COORD_FRAC_BITS = sfb_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   sfb_if.sink         req,
   sfb_if.source       rsp
);
   import sfb_pkg::*;

   logic [BOX_W-1:0]         box_left_ff, box_top_ff, box_width_ff, box_height_ff;
   logic signed [TRIG_W-1:0] cos_ff, sin_ff;
   dp_cmd_type               cmd;
   dp_stat_type              stat;
   logic signed [COORD_W-1:0] out_x, out_y, scaled_cos, scaled_sin;
   logic [CENTRE_W-1:0]      center_x, center_y;
   logic                     last_out;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         box_left_ff   <= '0;
         box_top_ff    <= '0;
         box_width_ff  <= 12'd256;
         box_height_ff <= 12'd256;
         cos_ff        <= 16'sh7FFF;
         sin_ff        <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_BOX_LEFT:   box_left_ff   <= csr_data[BOX_W-1:0];
            REG_BOX_TOP:    box_top_ff    <= csr_data[BOX_W-1:0];
            REG_BOX_WIDTH:  box_width_ff  <= csr_data[BOX_W-1:0];
            REG_BOX_HEIGHT: box_height_ff <= csr_data[BOX_W-1:0];
            REG_COS:        cos_ff        <= csr_data;
            REG_SIN:        sin_ff        <= csr_data;
            default: ;
         endcase
      end
   end

   sfb_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_last(req.data[0]), .req_ready(req.ready),
      .rsp_ready(rsp.ready), .stat, .cmd);

   sfb_dp #(.MAX_POINTS(MAX_POINTS), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_dp (
      .clock, .reset, .cmd, .stat,
      .point_x(req.data[48:25]), .point_y(req.data[24:1]),
      .box_left(box_left_ff), .box_top(box_top_ff),
      .box_width(box_width_ff), .box_height(box_height_ff),
      .cos_rotation(cos_ff), .sin_rotation(sin_ff),
      .rsp_ready(rsp.ready),
      .out_x, .out_y, .scaled_cos, .scaled_sin, .center_x, .center_y, .last_out);

   assign rsp.valid = stat.out_valid;
   assign rsp.data  = {out_x, out_y, scaled_cos, scaled_sin, center_x, center_y, last_out};

   // no input taken while results are pending
   a_no_req_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("input taken during output walk");
   // a result with last_out returns the block to loading
   a_last_returns: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && last_out) |=> req.ready)
      else $error("block did not return to loading");
   // a stalled result holds its out_x and last_out
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> $stable(out_x) && $stable(last_out))
      else $error("output changed under stall");
endmodule

[tb/shape_fit_to_box_transform_tb.sv]
// Self-checking testbench for shape_fit_to_box_transform: point sets in on req,
// placed points out on rsp, checked against a behavioural predictor.
// Depends on sfb_pkg, sfb_if and the block's RTL.
`timescale 1ns / 1ps

module shape_fit_to_box_transform_tb;
   import sfb_pkg::*;

   localparam int STORE_DEPTH = MAX_POINTS_DEF;
   localparam int FRAC        = COORD_FRAC_BITS_DEF;
   localparam int REQ_W       = 2 * COORD_W + 1;
   localparam int RSP_W       = 4 * COORD_W + 2 * CENTRE_W + 1;
   localparam int IDLE_LIMIT  = 20000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] scaled_cos;
      logic signed [COORD_W-1:0] scaled_sin;
      logic [CENTRE_W-1:0]       center_x;
      logic [CENTRE_W-1:0]       center_y;
      logic                      last_out;
   } placed_type;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      bit                        last;
      bit                        typed;
      logic signed [COORD_W-1:0] ex_x;
      logic signed [COORD_W-1:0] ex_y;
      logic signed [COORD_W-1:0] ex_cos;
   } directed_row_type;

   logic clock;
   logic reset;
   logic csr_write;
   logic [2:0] csr_index;
   logic [15:0] csr_data;

   sfb_if #(.WIDTH(REQ_W)) req_chan ();
   sfb_if #(.WIDTH(RSP_W)) rsp_chan ();

   shape_fit_to_box_transform u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req       (req_chan),
      .rsp       (rsp_chan)
   );

   // shadow configuration
   longint box_left_q, box_top_q, box_width_q, box_height_q, cos_q, sin_q;

   // shadow point set
   longint set_x [STORE_DEPTH];
   longint set_y [STORE_DEPTH];
   longint set_count, acc_x, acc_y, lo_x, hi_x, lo_y, hi_y;

   placed_type placed_q[$];
   placed_type typed_q[$];

   int  fail_count;
   int  points_sent;
   int  idle_cycles;
   bit  hold_request;
   bit  no_idle;
   int  burst_left;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint sat24(input longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   function automatic longint floor_div(input longint a, input longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint round_shr(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   // fold one accepted point into the set; on the last point place the whole set
   task automatic place_point(input longint x, input longint y, input bit last);
      longint mean_x, mean_y, wd, ht, scale, sc, ss, cx, cy, dx, dy, num, den;
      placed_type e;
      placed_type t;
      bit have_typed;
      if (set_count < STORE_DEPTH) begin
         set_x[set_count] = x;
         set_y[set_count] = y;
         if (set_count == 0) begin
            lo_x = x; hi_x = x; lo_y = y; hi_y = y;
         end else begin
            if (x < lo_x) lo_x = x;
            if (x > hi_x) hi_x = x;
            if (y < lo_y) lo_y = y;
            if (y > hi_y) hi_y = y;
         end
         acc_x += x;
         acc_y += y;
         set_count++;
      end
      if (!last || set_count == 0) return;
      mean_x = floor_div(2 * acc_x + set_count, 2 * set_count);
      mean_y = floor_div(2 * acc_y + set_count, 2 * set_count);
      wd = hi_x - lo_x;
      ht = hi_y - lo_y;
      if (wd == 0 && ht == 0) begin
         scale = 64'hFF_FFFF;
      end else begin
         if (wd > 0 && box_width_q * ht <= box_height_q * wd) begin
            num = box_width_q; den = wd;
         end else begin
            num = box_height_q; den = ht;
         end
         scale = (num <<< (FRAC + 16)) / den;
         if (scale > 64'hFF_FFFF) scale = 64'hFF_FFFF;
      end
      sc = sat24(round_shr(scale * cos_q, 15));
      ss = sat24(round_shr(scale * sin_q, 15));
      cx = (2 * box_left_q + box_width_q) <<< (FRAC - 1);
      cy = (2 * box_top_q + box_height_q) <<< (FRAC - 1);
      if (cx > 64'h1F_FFFF) cx = 64'h1F_FFFF;
      if (cy > 64'h1F_FFFF) cy = 64'h1F_FFFF;
      have_typed = (typed_q.size() != 0);
      if (have_typed) t = typed_q.pop_front();
      for (int i = 0; i < set_count; i++) begin
         dx = set_x[i] - mean_x;
         dy = set_y[i] - mean_y;
         e.out_x      = sat24(round_shr(sc * dx + ss * dy, 16) + cx);
         e.out_y      = sat24(round_shr(sc * dy - ss * dx, 16) + cy);
         e.scaled_cos = sc;
         e.scaled_sin = ss;
         e.center_x   = cx;
         e.center_y   = cy;
         e.last_out   = (i + 1 == set_count);
         // hand-worked values replace the predicted ones
         if (have_typed && i == 0) begin
            e.out_x      = t.out_x;
            e.out_y      = t.out_y;
            e.scaled_cos = t.scaled_cos;
         end
         placed_q.push_back(e);
      end
      set_count = 0;
      acc_x = 0; acc_y = 0;
      lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
   endtask

   // input monitor: predict on every transfer
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         place_point($signed(req_chan.data[REQ_W-1 -: COORD_W]),
                     $signed(req_chan.data[1 +: COORD_W]),
                     req_chan.data[0]);
   end

   // output monitor: compare each transfer with the oldest expectation
   always @(posedge clock) begin
      placed_type got;
      placed_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.data;
         if (placed_q.size() == 0) begin
            $error("unexpected result transfer %h", got);
            fail_count++;
         end else begin
            want = placed_q.pop_front();
            if (got.out_x !== want.out_x) begin
               $error("out_x exp %0d got %0d", want.out_x, got.out_x); fail_count++;
            end
            if (got.out_y !== want.out_y) begin
               $error("out_y exp %0d got %0d", want.out_y, got.out_y); fail_count++;
            end
            if (got.scaled_cos !== want.scaled_cos) begin
               $error("scaled_cos exp %0d got %0d", want.scaled_cos, got.scaled_cos);
               fail_count++;
            end
            if (got.scaled_sin !== want.scaled_sin) begin
               $error("scaled_sin exp %0d got %0d", want.scaled_sin, got.scaled_sin);
               fail_count++;
            end
            if (got.center_x !== want.center_x) begin
               $error("center_x exp %0d got %0d", want.center_x, got.center_x); fail_count++;
            end
            if (got.center_y !== want.center_y) begin
               $error("center_y exp %0d got %0d", want.center_y, got.center_y); fail_count++;
            end
            if (got.last_out !== want.last_out) begin
               $error("last_out exp %0d got %0d", want.last_out, got.last_out); fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: random stall pattern, with a long hold when asked
   initial begin
      int ready_pct;
      rsp_chan.ready = 1'b0;
      ready_pct = 100;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if ($urandom_range(0, 199) == 0) begin
            case ($urandom_range(0, 2))
               0: ready_pct = 100;
               1: ready_pct = 70;
               default: ready_pct = 25;
            endcase
         end
         rsp_chan.ready <= ($urandom_range(0, 99) < ready_pct);
      end
   end

   // one point transfer, with gaps between bursts
   task automatic send_point(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y, input bit last);
      int gap;
      if (burst_left == 0) begin
         gap = no_idle ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= {x, y, last};
      do @(posedge clock); while (!req_chan.ready);
      burst_left--;
      points_sent++;
   endtask

   // wait until every expected result has come and the walk has wound down
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (placed_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input longint value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[15:0];
      case (idx)
         REG_BOX_LEFT:   box_left_q   = value & 12'hFFF;
         REG_BOX_TOP:    box_top_q    = value & 12'hFFF;
         REG_BOX_WIDTH:  box_width_q  = value & 12'hFFF;
         REG_BOX_HEIGHT: box_height_q = value & 12'hFFF;
         REG_COS:        cos_q        = $signed(value[15:0]);
         default:        sin_q        = $signed(value[15:0]);
      endcase
      @(posedge clock);
   endtask

   task automatic configure(input longint l, t, w, h, c, s);
      write_reg(REG_BOX_LEFT, l);
      write_reg(REG_BOX_TOP, t);
      write_reg(REG_BOX_WIDTH, w);
      write_reg(REG_BOX_HEIGHT, h);
      write_reg(REG_COS, c);
      write_reg(REG_SIN, s);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // one random point set: mostly small, a few full or overflowing the store
   task automatic send_set();
      int n, r, kind;
      logic signed [COORD_W-1:0] x, y, fx, fy;
      r = $urandom_range(0, 99);
      if (r < 75)      n = $urandom_range(1, 8);
      else if (r < 85) n = $urandom_range(9, 30);
      else if (r < 93) n = STORE_DEPTH;
      else             n = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 4);
      kind = $urandom_range(0, 19);
      fx = $urandom;
      fy = $urandom;
      for (int i = 0; i < n; i++) begin
         if (kind < 9) begin
            x = $urandom; y = $urandom;
         end else begin
            x = $signed($urandom_range(0, 8000)) - 4000;
            y = $signed($urandom_range(0, 8000)) - 4000;
         end
         // flat sets give a zero extent on one or both axes
         if (kind == 18 || kind == 19) x = fx;
         if (kind == 17 || kind == 19) y = fy;
         send_point(x, y, i == n - 1);
      end
   endtask

   // stimulus
   initial begin
      directed_row_type rows[$];
      directed_row_type row;
      placed_type t;
      int phase;
      reset     = 1'b1;
      csr_write = 1'b0;
      csr_index = REG_BOX_LEFT;
      csr_data  = '0;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      fail_count = 0; points_sent = 0; idle_cycles = 0;
      hold_request = 1'b0; no_idle = 1'b0; burst_left = 0;
      box_left_q = 0; box_top_q = 0; box_width_q = 256; box_height_q = 256;
      cos_q = 32767; sin_q = 0;
      set_count = 0; acc_x = 0; acc_y = 0; lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed sets at reset configuration
      // single point: zero extent saturates the scale, output sits on the centre
      rows.push_back('{24'sd0, 24'sd0, 1, 1, 24'sd32768, 24'sd32768, 24'sd8388607});
      // coordinate extremes
      rows.push_back('{24'sh7FFFFF, 24'sh800000, 0, 0, 0, 0, 0});
      rows.push_back('{24'sh800000, 24'sh7FFFFF, 1, 0, 0, 0, 0});
      // zero width only
      rows.push_back('{24'sd5, 24'sd0, 0, 0, 0, 0, 0});
      rows.push_back('{24'sd5, 24'sd1000, 1, 0, 0, 0, 0});
      // zero height only
      rows.push_back('{-24'sd700, 24'sd9, 0, 0, 0, 0, 0});
      rows.push_back('{24'sd300, 24'sd9, 1, 0, 0, 0, 0});
      // ordinary small set
      rows.push_back('{24'sd256, -24'sd512, 0, 0, 0, 0, 0});
      rows.push_back('{-24'sd256, 24'sd128, 0, 0, 0, 0, 0});
      rows.push_back('{24'sd1, 24'sd3, 1, 0, 0, 0, 0});
      foreach (rows[i]) begin
         row = rows[i];
         if (row.typed) begin
            t = '0;
            t.out_x = row.ex_x; t.out_y = row.ex_y; t.scaled_cos = row.ex_cos;
            typed_q.push_back(t);
         end
         send_point(row.x, row.y, row.last);
      end
      drain();

      // store overflow: dropped points, last one still closes the set
      for (int i = 0; i < STORE_DEPTH + 3; i++)
         send_point($signed($urandom_range(0, 2000)) - 1000, i * 7, i == STORE_DEPTH + 2);
      drain();

      // configuration phases, extremes first, then random
      phase = 0;
      while (points_sent < 360) begin
         case (phase)
            0: configure(0, 0, 4095, 1, -32768, 32767);
            1: configure(4095, 4095, 4095, 4095, 32767, -32768);
            2: configure(10, 20, 0, 100, 23170, 23170);
            3: configure(100, 5, 1, 0, 0, -32768);
            4: configure(2000, 3000, 1, 1, 0, 0);
            default: configure($urandom_range(0, 4095), $urandom_range(0, 4095),
                               $urandom_range(1, 4095), $urandom_range(1, 4095),
                               $urandom_range(0, 65535), $urandom_range(0, 65535));
         endcase
         no_idle = ($urandom_range(0, 3) == 0);
         if (phase == 2) hold_request = 1'b1;
         repeat ($urandom_range(3, 6)) send_set();
         drain();
         phase++;
      end

      // wait for the last results and the walk to finish
      if (placed_q.size() != 0) drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && placed_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
